// ===== hdl/tvps_pkg.sv =====
// shared types, codes and helpers for the tracker volume/pan slide unit
// no dependencies; used by the front, queue, back and top level files
package tvps_pkg;

    // input kind codes
    localparam logic [1:0] KIND_SAMPLE  = 2'd0;
    localparam logic [1:0] KIND_CHANNEL = 2'd1;
    localparam logic [1:0] KIND_PAN     = 2'd2;

    // format mode codes (any other value means other formats)
    localparam logic [1:0] FMT_MOD = 2'd0;
    localparam logic [1:0] FMT_S3M = 2'd1;

    // configuration register indexes
    localparam logic CFG_FORMAT_MODE = 1'b0;
    localparam logic CFG_FAST_SLIDES = 1'b1;

    // reset values of configuration and levels
    localparam logic [1:0] FORMAT_MODE_RESET = 2'd2;
    localparam logic [7:0] SAMPLE_MAX        = 8'd128;
    localparam logic [6:0] CHANNEL_MAX       = 7'd64;
    localparam logic [8:0] PAN_MAX           = 9'd256;
    localparam logic [8:0] PAN_CENTRE        = 9'd128;

    // s3m first-tick step of a plain fine-marker slide
    localparam logic [7:0] FIRST_TICK_STEP = 8'h1E;
    localparam logic [3:0] NIBBLE_FULL     = 4'hF;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // one classified slide, as passed from front to back
    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] lo;
        logic [3:0] hi;
        logic       tick_eq_start;
        logic       tick_gt_start;
        logic       tick_zero;
    } t_slide_op;

    // saturate a signed sum into 0..hi
    function automatic logic [8:0] clip_level(input logic signed [10:0] v,
                                              input logic [8:0] hi);
        logic [8:0] r;
        if (v < 0) begin
            r = 9'd0;
        end else if (v > $signed({2'b00, hi})) begin
            r = hi;
        end else begin
            r = v[8:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/tvps_in_if.sv =====
// input channel of the slide unit: one slide effect per item
// depends on nothing
interface tvps_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] param;
    logic [7:0] tick;
    logic [7:0] row_start_tick;

    modport source (output valid, kind, param, tick, row_start_tick, input ready);
    modport sink   (input valid, kind, param, tick, row_start_tick, output ready);
endinterface

// ===== hdl/tvps_out_if.sv =====
// result channel of the slide unit: all three levels and the ramp flag
// depends on nothing
interface tvps_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] sample_volume;
    logic [6:0] channel_volume;
    logic [8:0] pan_position;
    logic       fast_ramp;

    modport source (output valid, sample_volume, channel_volume, pan_position, fast_ramp,
                    input ready);
    modport sink   (input valid, sample_volume, channel_volume, pan_position, fast_ramp,
                    output ready);
endinterface

// ===== hdl/tvps_cfg_if.sv =====
// configuration write channel of the slide unit
// depends on nothing
interface tvps_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/tvps_front.sv =====
// front end: accepts items, resolves remembered parameters, classifies ticks
// depends on tvps_pkg and tvps_in_if
module tvps_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tvps_in_if.sink           i_in,
    input  logic              i_queue_full,
    output logic              o_push,
    output tvps_pkg::t_slide_op o_push_op
);
    import tvps_pkg::*;

    logic       accept;
    logic [7:0] r_sample_mem, r_channel_mem, r_pan_mem;
    logic [7:0] mem_sel;
    logic [7:0] param_eff;

    assign i_in.ready = !i_queue_full;
    assign accept     = i_in.valid && !i_queue_full;
    assign o_push     = accept;

    // pick the remembered parameter of the addressed effect
    always_comb begin
        case (i_in.kind)
            KIND_SAMPLE:  mem_sel = r_sample_mem;
            KIND_CHANNEL: mem_sel = r_channel_mem;
            KIND_PAN:     mem_sel = r_pan_mem;
            default:      mem_sel = 8'd0;
        endcase
        param_eff = (i_in.param == 8'd0) ? mem_sel : i_in.param;
    end

    // classify the item for the back end
    always_comb begin
        o_push_op.kind          = i_in.kind;
        o_push_op.lo            = param_eff[3:0];
        o_push_op.hi            = param_eff[7:4];
        o_push_op.tick_eq_start = (i_in.tick == i_in.row_start_tick);
        o_push_op.tick_gt_start = (i_in.tick > i_in.row_start_tick);
        o_push_op.tick_zero     = (i_in.tick == 8'd0);
    end

    // remember the last nonzero parameter per effect
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_mem  <= 8'd0;
            r_channel_mem <= 8'd0;
            r_pan_mem     <= 8'd0;
        end else if (accept && i_in.param != 8'd0) begin
            case (i_in.kind)
                KIND_SAMPLE:  r_sample_mem  <= i_in.param;
                KIND_CHANNEL: r_channel_mem <= i_in.param;
                KIND_PAN:     r_pan_mem     <= i_in.param;
                default: ;
            endcase
        end
    end

endmodule

// ===== hdl/tvps_queue.sv =====
// short queue of classified slides between front and back
// depends on tvps_pkg
module tvps_queue #(
    parameter int DEPTH = tvps_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tvps_pkg::t_slide_op i_push_op,
    output logic                o_full,
    output logic                o_valid,
    input  logic                i_pop,
    output tvps_pkg::t_slide_op o_pop_op
);
    import tvps_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_slide_op        r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full   = (r_count == CNT_FULL);
    assign o_valid  = (r_count != '0);
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && o_valid;
    assign o_pop_op = r_slot[r_rd_ptr];

    // slot storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push_op;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hdl/tvps_back.sv =====
// back end: applies one slide to the levels and registers the result
// depends on tvps_pkg and tvps_out_if
module tvps_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_format_mode,
    input  logic                i_fast_slides,
    input  logic                i_op_valid,
    input  tvps_pkg::t_slide_op i_op,
    output logic                o_op_pop,
    tvps_out_if.source          o_out
);
    import tvps_pkg::*;

    logic [7:0] r_sample_level;
    logic [6:0] r_channel_level;
    logic [8:0] r_pan_level;
    logic       r_out_valid;
    logic       r_fast_ramp;

    logic       take;
    logic       fm_mod, fm_s3m, eq, gt, fast;
    logic       fine_up, fine_dn;
    logic signed [10:0] s_delta, c_delta, p_delta;
    logic       ramp;
    logic [8:0] s_clip, c_clip, p_clip;
    logic [7:0] n_sample_level;
    logic [6:0] n_channel_level;
    logic [8:0] n_pan_level;

    assign take     = i_op_valid && (!r_out_valid || o_out.ready);
    assign o_op_pop = take;

    assign fm_mod  = (i_format_mode == FMT_MOD);
    assign fm_s3m  = (i_format_mode == FMT_S3M);
    assign eq      = i_op.tick_eq_start;
    assign gt      = i_op.tick_gt_start;
    assign fast    = i_fast_slides;
    assign fine_up = fm_s3m && i_op.lo == NIBBLE_FULL && i_op.hi != 4'd0;
    assign fine_dn = fm_s3m && i_op.hi == NIBBLE_FULL && i_op.lo != 4'd0 && !fine_up;

    // sample volume step, fine and s3m first-tick rules
    always_comb begin
        s_delta = '0;
        ramp    = 1'b0;
        if (fine_up) begin
            if (eq) s_delta = $signed({6'b0, i_op.hi, 1'b0});
        end else if (fine_dn) begin
            if (eq) s_delta = -$signed({6'b0, i_op.lo, 1'b0});
        end else begin
            if (fm_s3m && eq && !fast && i_op.lo == NIBBLE_FULL && i_op.hi == 4'd0) begin
                s_delta = -$signed({3'b0, FIRST_TICK_STEP});
            end
            if (fm_s3m && eq && !fast && i_op.hi == NIBBLE_FULL && i_op.lo == 4'd0) begin
                s_delta = $signed({3'b0, FIRST_TICK_STEP});
            end
            if (gt || fast) begin
                if (i_op.hi != 4'd0 && i_op.lo == 4'd0) begin
                    s_delta = $signed({6'b0, i_op.hi, 1'b0});
                end else if (i_op.lo != 4'd0 && i_op.hi == 4'd0) begin
                    s_delta = -$signed({6'b0, i_op.lo, 1'b0});
                end
                ramp = fm_mod;
            end
        end
    end

    // channel volume step, fine slides on tick zero, plain slides on other ticks
    always_comb begin
        c_delta = '0;
        if (i_op.tick_zero) begin
            if (i_op.hi == NIBBLE_FULL && i_op.lo != 4'd0) begin
                c_delta = -$signed({7'b0, i_op.lo});
            end else if (i_op.lo == NIBBLE_FULL && i_op.hi != 4'd0) begin
                c_delta = $signed({7'b0, i_op.hi});
            end
        end else if (i_op.lo != 4'd0) begin
            c_delta = -$signed({7'b0, i_op.lo});
        end else begin
            c_delta = $signed({7'b0, i_op.hi});
        end
    end

    // panning step, fine slides on tick zero, plain slides on other ticks
    always_comb begin
        p_delta = '0;
        if (i_op.tick_zero) begin
            if (i_op.lo == NIBBLE_FULL && i_op.hi != 4'd0) begin
                p_delta = -$signed({5'b0, i_op.hi, 2'b0});
            end else if (i_op.hi == NIBBLE_FULL && i_op.lo != 4'd0) begin
                p_delta = $signed({5'b0, i_op.lo, 2'b0});
            end
        end else if (i_op.hi != 4'd0) begin
            p_delta = -$signed({5'b0, i_op.hi, 2'b0});
        end else begin
            p_delta = $signed({5'b0, i_op.lo, 2'b0});
        end
    end

    // saturate and select the level that this kind touches
    always_comb begin
        s_clip = clip_level($signed({3'b0, r_sample_level}) + s_delta, {1'b0, SAMPLE_MAX});
        c_clip = clip_level($signed({4'b0, r_channel_level}) + c_delta, {2'b0, CHANNEL_MAX});
        p_clip = clip_level($signed({2'b0, r_pan_level}) + p_delta, PAN_MAX);
        n_sample_level  = r_sample_level;
        n_channel_level = r_channel_level;
        n_pan_level     = r_pan_level;
        case (i_op.kind)
            KIND_SAMPLE:  n_sample_level  = s_clip[7:0];
            KIND_CHANNEL: n_channel_level = c_clip[6:0];
            KIND_PAN:     n_pan_level     = p_clip;
            default: ;
        endcase
    end

    // levels double as the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_level  <= SAMPLE_MAX;
            r_channel_level <= CHANNEL_MAX;
            r_pan_level     <= PAN_CENTRE;
            r_fast_ramp     <= 1'b0;
            r_out_valid     <= 1'b0;
        end else if (take) begin
            r_sample_level  <= n_sample_level;
            r_channel_level <= n_channel_level;
            r_pan_level     <= n_pan_level;
            r_fast_ramp     <= ramp && (i_op.kind == KIND_SAMPLE);
            r_out_valid     <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid     <= 1'b0;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.sample_volume  = r_sample_level;
    assign o_out.channel_volume = r_channel_level;
    assign o_out.pan_position   = r_pan_level;
    assign o_out.fast_ramp      = r_fast_ramp;

`ifndef NO_ASSERTIONS
    // levels never leave their ranges
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_sample_level <= SAMPLE_MAX && r_channel_level <= CHANNEL_MAX
                         && r_pan_level <= PAN_MAX))
        else $error("slide level out of range");

    // fast ramp only under mod rules
    a_ramp_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_fast_ramp) |-> (i_format_mode == FMT_MOD))
        else $error("fast ramp outside mod rules");

    // levels only move when an op is taken
    a_levels_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !take) |=> ($stable(r_sample_level) && $stable(r_channel_level)
                                && $stable(r_pan_level)))
        else $error("levels changed without an op");

    // a taken op always produces a result
    a_take_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_out_valid)
        else $error("taken op lost its result");
`endif

endmodule

// ===== hdl/tracker_volume_pan_slide_unit.sv =====
// top level of the tracker volume/pan slide unit: config registers and wiring
// depends on tvps_pkg, the channel interfaces, tvps_front, tvps_queue, tvps_back
//
// usage:
//   i_in   slide items (kind, param, tick, row_start_tick), valid/ready
//   o_out  one result per item: sample volume, channel volume, pan, fast ramp
//   i_cfg  register writes: index 0 format mode, index 1 fast slides;
//          always ready, write only while no item is in flight
// path: the front classifies an accepted item and registers it into the
//   queue, and the back end then updates the levels from it into the
//   output register
// throughput: one item per cycle while the receiver holds ready high; the
//   back end level update is the only loop
// reset: levels go to 128/64/128, parameter memories to 0, format mode 2,
//   fast slides 0; queue and output are empty
// stall: when the receiver holds ready low the result stays put, the queue
//   takes up to QUEUE_DEPTH further items, then i_in.ready drops
module tracker_volume_pan_slide_unit #(
    parameter int QUEUE_DEPTH = tvps_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tvps_in_if.sink    i_in,
    tvps_cfg_if.sink   i_cfg,
    tvps_out_if.source o_out
);
    import tvps_pkg::*;

    logic [1:0] r_format_mode;
    logic       r_fast_slides;
    logic       push, queue_full, op_valid, op_pop;
    t_slide_op  push_op, pop_op;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format_mode <= FORMAT_MODE_RESET;
            r_fast_slides <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_FORMAT_MODE: r_format_mode <= i_cfg.data;
                CFG_FAST_SLIDES: r_fast_slides <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // front: accept and classify
    tvps_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_push_op    (push_op)
    );

    // queue between the two sides
    tvps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_op (push_op),
        .o_full    (queue_full),
        .o_valid   (op_valid),
        .i_pop     (op_pop),
        .o_pop_op  (pop_op)
    );

    // back: apply slides and present results
    tvps_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_format_mode (r_format_mode),
        .i_fast_slides (r_fast_slides),
        .i_op_valid    (op_valid),
        .i_op          (pop_op),
        .o_op_pop      (op_pop),
        .o_out         (o_out)
    );

endmodule
